// ===== design/tail_drop_queue_round_robin_ci_defines.svh =====
// Assertion macros for the tail-drop queue.
`ifndef TAIL_DROP_QUEUE_ROUND_ROBIN_CI_DEFINES_SVH
`define TAIL_DROP_QUEUE_ROUND_ROBIN_CI_DEFINES_SVH
`ifndef SYNTH
`define TDQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TDQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define TDQ_ASSERT(label, clk, rst_n, prop, msg)
`define TDQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== design/tdq_pkg.sv =====
package tdq_pkg;
	localparam int QueueDepthDef = 128;
	localparam int MaxPortsDef = 8;
	localparam int IdWidthDef = 32;
	localparam logic [2:0] EV_ENQ = 3'd0;
	localparam logic [2:0] EV_DROP = 3'd1;
	localparam logic [2:0] EV_SENT = 3'd2;
	localparam logic [2:0] EV_EMPTY = 3'd3;
	localparam logic [2:0] EV_BUSY = 3'd4;
	localparam logic [0:0] REG_CAPACITY = 1'd0;
	localparam logic [0:0] REG_PORTS = 1'd1;
	localparam logic [16:0] FILL_WEIGHT = 17'd45875;
	localparam logic [16:0] LOSS_WEIGHT = 17'd19661;
	localparam logic [15:0] FEEDBACK_LIMIT = 16'd9830;

	// front to back: one classified item
	typedef struct packed {
		logic [2:0] code;
		logic [2:0] port;
		logic [31:0] sent_id;
		logic [7:0] occ;
		logic [7:0] cap;
		logic [31:0] drops;
		logic fb;
	} tdq_job_t;
endpackage

// ===== design/tdq_front.sv =====
`include "tail_drop_queue_round_robin_ci_defines.svh"
module tdq_front import tdq_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepthDef,
	parameter int MAX_PORTS = MaxPortsDef,
	parameter int ID_WIDTH = IdWidthDef
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic func,
	input logic [ID_WIDTH-1:0] packet_id,
	input logic [7:0] port_ready_mask,
	input logic [15:0] feedback_draw,
	input logic [7:0] cap_q,
	input logic [3:0] ports_q,
	output logic job_valid,
	output tdq_job_t job,
	input logic job_stall
);
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int OW = $clog2(QUEUE_DEPTH + 1);
	localparam int PW = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;

	logic [ID_WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [AW-1:0] head_q, tail_q;
	logic [OW-1:0] occ_q;
	logic [31:0] drops_q;
	logic [PW-1:0] rot_q;
	logic rd_pend_q;
	logic [ID_WIDTH-1:0] rd_data_q;
	tdq_job_t hold_q;
	logic full_q;

	logic [8:0] cap_eff;
	logic [6:0] cnt;
	logic [6:0] sel;
	logic take, fire;
	tdq_job_t j;
	logic [OW-1:0] occ_n;
	logic [31:0] drops_n;

	assign in_stall = full_q || rd_pend_q;
	assign take = in_valid && !in_stall;
	assign job_valid = full_q && !rd_pend_q;
	assign fire = job_valid && !job_stall;

	always_comb begin
		j = '0;
		occ_n = occ_q;
		drops_n = drops_q;
		cap_eff = (32'(cap_q) > QUEUE_DEPTH) ? 9'(QUEUE_DEPTH) : 9'(cap_q);
		cnt = (7'(ports_q) > 7'(MAX_PORTS)) ? 7'(MAX_PORTS) : 7'(ports_q);
		sel = (7'(rot_q) < cnt) ? 7'(rot_q) : 7'd0;
		if (!func) begin
			if (9'(occ_q) >= cap_eff) begin
				j.code = EV_DROP;
				if (drops_q != '1) drops_n = drops_q + 32'd1;
			end else begin
				j.code = EV_ENQ;
				occ_n = occ_q + 1'b1;
			end
		end else if (occ_q == '0 || cnt == '0) begin
			j.code = EV_EMPTY;
		end else begin
			j.port = 3'(sel);
			if (sel < 7'd8 && port_ready_mask[sel[2:0]]) begin
				j.code = EV_SENT;
				occ_n = occ_q - 1'b1;
				j.fb = feedback_draw < FEEDBACK_LIMIT;
			end else begin
				j.code = EV_BUSY;
			end
		end
		j.occ = 8'(occ_n);
		j.cap = cap_q;
		j.drops = drops_n;
	end

	always_ff @(posedge clk) begin
		if (take && !func && j.code == EV_ENQ) mem_q[tail_q] <= packet_id;
		rd_data_q <= mem_q[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q <= '0;
			drops_q <= '0;
			rot_q <= '0;
			full_q <= 1'b0;
			rd_pend_q <= 1'b0;
			hold_q <= '0;
		end else begin
			rd_pend_q <= 1'b0;
			if (fire) full_q <= 1'b0;
			if (rd_pend_q && hold_q.code == EV_SENT) hold_q.sent_id <= 32'(rd_data_q);
			if (take) begin
				full_q <= 1'b1;
				hold_q <= j;
				occ_q <= occ_n;
				drops_q <= drops_n;
				if (j.code == EV_ENQ)
					tail_q <= (32'(tail_q) == QUEUE_DEPTH - 1) ? '0 : tail_q + 1'b1;
				if (j.code == EV_SENT || j.code == EV_BUSY)
					rot_q <= (sel + 7'd1 >= cnt) ? '0 : PW'(sel + 7'd1);
				if (j.code == EV_SENT) begin
					rd_pend_q <= 1'b1;
					head_q <= (32'(head_q) == QUEUE_DEPTH - 1) ? '0 : head_q + 1'b1;
				end
			end
		end
	end

	assign job = hold_q;

	`TDQ_ASSERT(a_occ_range, clk, arst_n, (32'(occ_q) <= QUEUE_DEPTH), "occupancy over depth")
	`TDQ_ASSERT_NEXT(a_rd_one, clk, arst_n, rd_pend_q, !rd_pend_q, "read pending twice")
	`TDQ_ASSERT_NEXT(a_drop_keep, clk, arst_n, (take && j.code != EV_DROP),
		(drops_q == $past(drops_q)), "drops moved without drop")
endmodule

// ===== design/tdq_back.sv =====
`include "tail_drop_queue_round_robin_ci_defines.svh"
module tdq_back import tdq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_stall,
	input tdq_job_t job,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] event_code,
	output logic [31:0] sent_id,
	output logic [2:0] out_port,
	output logic [15:0] congestion_index,
	output logic feedback_flag,
	output logic [31:0] drops_total
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_OUT = 2'd2;

	logic [1:0] st_q;
	tdq_job_t job_q;
	logic phase_q;
	logic [5:0] step_q;
	logic [48:0] num_q;
	logic [32:0] den_q;
	logic [33:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] fill_q;
	logic [33:0] trial;
	logic [16:0] sum;

	assign job_stall = st_q != ST_IDLE;
	// a sent result waits in ST_OUT until its index is registered
	assign out_valid = (st_q == ST_OUT) && !(job_q.code == EV_SENT && step_q == '0);
	assign trial = {rem_q[32:0], num_q[48]} - {1'b0, den_q};
	assign sum = 17'(fill_q) + 17'(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			phase_q <= 1'b0;
			step_q <= '0;
			job_q <= '0;
			num_q <= '0;
			den_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			fill_q <= '0;
			congestion_index <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (job_valid) begin
						job_q <= job;
						congestion_index <= '0;
						if (job.code == EV_SENT) begin
							st_q <= ST_DIV;
							phase_q <= 1'b0;
							step_q <= '0;
							rem_q <= '0;
							num_q <= 49'(FILL_WEIGHT) * 49'(job.occ);
							den_q <= 33'(job.cap);
							if (job.cap == '0 || job.occ >= job.cap) begin
								fill_q <= 16'(FILL_WEIGHT);
								phase_q <= 1'b1;
								num_q <= 49'(LOSS_WEIGHT) * 49'(job.drops);
								den_q <= 33'(job.drops) + 33'd1;
							end
						end else begin
							st_q <= ST_OUT;
						end
					end
				end
				ST_DIV: begin
					num_q <= {num_q[47:0], 1'b0};
					step_q <= step_q + 6'd1;
					if (!trial[33]) begin
						rem_q <= trial;
						quo_q <= {quo_q[14:0], 1'b1};
					end else begin
						rem_q <= {rem_q[32:0], num_q[48]};
						quo_q <= {quo_q[14:0], 1'b0};
					end
					if (step_q == 6'd48) begin
						step_q <= '0;
						rem_q <= '0;
						if (!phase_q) begin
							fill_q <= (!trial[33]) ? {quo_q[14:0], 1'b1} : {quo_q[14:0], 1'b0};
							phase_q <= 1'b1;
							num_q <= 49'(LOSS_WEIGHT) * 49'(job_q.drops);
							den_q <= 33'(job_q.drops) + 33'd1;
						end else begin
							quo_q <= (!trial[33]) ? {quo_q[14:0], 1'b1} : {quo_q[14:0], 1'b0};
							st_q <= ST_OUT;
							phase_q <= 1'b0;
						end
					end
				end
				ST_OUT: begin
					if (job_q.code == EV_SENT && phase_q == 1'b0 && step_q == '0) begin
						congestion_index <= sum[16] ? 16'hFFFF : sum[15:0];
						step_q <= 6'd1;
					end else if (!out_stall) begin
						st_q <= ST_IDLE;
						step_q <= '0;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign event_code = job_q.code;
	assign sent_id = (job_q.code == EV_SENT) ? job_q.sent_id : '0;
	assign out_port = job_q.port;
	assign feedback_flag = job_q.fb;
	assign drops_total = job_q.drops;

	`TDQ_ASSERT(a_busy, clk, arst_n, (out_valid |-> job_stall), "output while accepting")
	`TDQ_ASSERT_NEXT(a_hold, clk, arst_n, (out_valid && out_stall && step_q != '0),
		$stable(congestion_index), "index changed under stall")
	`TDQ_ASSERT(a_step, clk, arst_n, (step_q <= 6'd48), "divider step over range")
endmodule

// ===== design/tail_drop_queue_round_robin_ci.sv =====
// Tail-drop output queue with round-robin send over up to MAX_PORTS ports.
// Input channel in_valid/in_stall carries one item: func 0 enqueues packet_id
// (dropped and counted when occupancy reaches the capacity), func 1 is a send
// opportunity that picks the next port in rotation and sends the head packet
// if that port's bit in port_ready_mask is set.
// Output channel out_valid/out_stall gives one result per item.
// Config channel cfg_valid/cfg_ready writes register cfg_index: 0 capacity,
// 1 port count. Write only while the block is idle.
// The congestion index of a sent packet takes two 49-step restoring divisions
// (only the second when the fill term saturates) in one shared bit-serial
// divider; the back takes no new job until it has given out its result.
// The front classifies and updates the queue; a one-entry job register parts
// it from the back, so the front accepts the next item while a result waits.
// Reset empties the queue, clears the drop counter and rotation pointer,
// capacity resets to 100 and port count to 1. A stalled result holds.
module tail_drop_queue_round_robin_ci import tdq_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepthDef,
	parameter int MAX_PORTS = MaxPortsDef,
	parameter int ID_WIDTH = IdWidthDef
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic func,
	input logic [ID_WIDTH-1:0] packet_id,
	input logic [7:0] port_ready_mask,
	input logic [15:0] feedback_draw,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] event_code,
	output logic [31:0] sent_id,
	output logic [2:0] out_port,
	output logic [15:0] congestion_index,
	output logic feedback_flag,
	output logic [31:0] drops_total,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [7:0] cfg_data
);
	logic [7:0] cap_q;
	logic [3:0] ports_q;
	logic job_valid, job_stall;
	tdq_job_t job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 8'd100;
			ports_q <= 4'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CAPACITY: cap_q <= cfg_data;
				REG_PORTS: ports_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	tdq_front #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_PORTS(MAX_PORTS), .ID_WIDTH(ID_WIDTH)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .func, .packet_id, .port_ready_mask,
		.feedback_draw, .cap_q, .ports_q, .job_valid, .job, .job_stall
	);

	tdq_back u_back (
		.clk, .arst_n, .job_valid, .job_stall, .job, .out_valid, .out_stall,
		.event_code, .sent_id, .out_port, .congestion_index, .feedback_flag, .drops_total
	);
endmodule
